[src/jsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared types and constants for the joystick axis circle clamp block.
// ----------------------------------------------------------------------------
package jsc_pkg;

  // input word: one axis update of one stick
  typedef struct packed {
    logic              stick;
    logic              axis;
    logic signed [15:0] value;
  } item_t;

  // result word: conditioned position of one stick
  typedef struct packed {
    logic              stick_out;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
  } result_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic clamp;
    logic sq_x;
    logic sq_y;
    logic sum;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_sel;
    logic div_step;
    logic store_x;
    logic store_y;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic big;
  } stat_t;

  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [15:0] NEG_ONE_Q14 = -16'sd16384;
  localparam logic signed [16:0] ONE_Q14_W     = 17'sd16384;
  localparam logic signed [16:0] NEG_ONE_Q14_W = -17'sd16384;
  localparam logic [29:0]        R2_ONE      = 30'd268435456;

  // iteration counts of the root and divide units
  localparam int unsigned SQRT_STEPS = 15;
  localparam int unsigned DIV_STEPS  = 15;
  localparam logic [3:0]  SQRT_LAST  = 4'(SQRT_STEPS - 1);
  localparam logic [3:0]  DIV_LAST   = 4'(DIV_STEPS - 1);

endpackage
`default_nettype wire

[src/jsc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jsc_ctrl
// Controller: sequences clamp, squares, root and divides, drives handshakes.
// ----------------------------------------------------------------------------
module jsc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  output logic               result_valid,
  input  wire logic          result_stall,
  input  jsc_pkg::stat_t     stat,
  output jsc_pkg::cmd_t      cmd
);
  import jsc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLAMP = 4'd1;
  localparam logic [3:0] S_SQX   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_TEST  = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DXI   = 4'd7;
  localparam logic [3:0] S_DX    = 4'd8;
  localparam logic [3:0] S_DYI   = 4'd9;
  localparam logic [3:0] S_DY    = 4'd10;
  localparam logic [3:0] S_DYS   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state, state_next;
  logic [3:0] cnt, cnt_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    item_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (stat.big) begin
          cmd.sqrt_init = 1'b1;
          cnt_next      = '0;
          state_next    = S_SQRT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == SQRT_LAST) begin
          cnt_next   = '0;
          state_next = S_DXI;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      S_DXI: begin
        cmd.div_init = 1'b1;
        cmd.div_sel  = 1'b0;
        cnt_next     = '0;
        state_next   = S_DX;
      end
      S_DX: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_DYI;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      S_DYI: begin
        // quotient of x is complete, start y on the same divider
        cmd.store_x  = 1'b1;
        cmd.div_init = 1'b1;
        cmd.div_sel  = 1'b1;
        cnt_next     = '0;
        state_next   = S_DY;
      end
      S_DY: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_DYS;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      S_DYS: begin
        cmd.store_y = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[src/jsc_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jsc_dp
// Datapath: raw axis store, clamp, shared squarer, bit-serial root and divider.
// ----------------------------------------------------------------------------
module jsc_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  jsc_pkg::item_t     item,
  input  jsc_pkg::cmd_t      cmd,
  output jsc_pkg::stat_t     stat,
  output jsc_pkg::result_t   result
);
  import jsc_pkg::*;

  logic signed [15:0] xs [2];
  logic signed [15:0] ys [2];
  logic               stk;

  logic signed [15:0] raw_x, raw_y, x_cl, y_cl;
  logic signed [16:0] neg_y;
  logic signed [15:0] x, y;

  logic signed [15:0] mul_in;
  logic signed [31:0] prod;
  logic [28:0]        sq_xq, sq_yq;
  logic [29:0]        r2;

  logic [16:0] sq_rem;
  logic [14:0] sq_root;
  logic [29:0] sq_rad;
  logic [18:0] sq_sh, sq_trial, sq_diff;
  logic        sq_ge;

  logic signed [15:0] dv_src, dv_abs;
  logic [14:0] dv_rem, dv_num, dv_q;
  logic        dv_neg;
  logic [15:0] dv_sh, dv_diff;
  logic        dv_ge;
  logic signed [15:0] dv_res;

  // raw axis store, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      xs[0] <= '0;
      xs[1] <= '0;
      ys[0] <= '0;
      ys[1] <= '0;
    end else if (cmd.load_in) begin
      if (item.axis) begin
        ys[item.stick] <= item.value;
      end else begin
        xs[item.stick] <= item.value;
      end
    end
  end

  always_comb begin
    raw_x = xs[stk];
    raw_y = ys[stk];
    if (raw_x > ONE_Q14) begin
      x_cl = ONE_Q14;
    end else if (raw_x < NEG_ONE_Q14) begin
      x_cl = NEG_ONE_Q14;
    end else begin
      x_cl = raw_x;
    end
    // vertical axis is inverted; -(-2.0) needs the extra bit
    neg_y = 17'sd0 - $signed({raw_y[15], raw_y});
    if (neg_y > ONE_Q14_W) begin
      y_cl = ONE_Q14;
    end else if (neg_y < NEG_ONE_Q14_W) begin
      y_cl = NEG_ONE_Q14;
    end else begin
      y_cl = neg_y[15:0];
    end
  end

  // shared squarer
  assign mul_in = cmd.sq_y ? y : x;
  assign prod   = mul_in * mul_in;

  assign stat.big = (r2 > R2_ONE);

  // restoring square root, two radicand bits a step
  assign sq_sh    = {sq_rem, sq_rad[29:28]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;

  // restoring divide of |axis| * 1.0 by the root, one quotient bit a step
  assign dv_src  = cmd.div_sel ? y : x;
  assign dv_abs  = dv_src[15] ? (16'sd0 - dv_src) : dv_src;
  assign dv_sh   = {dv_rem, dv_num[14]};
  assign dv_ge   = (dv_sh >= {1'b0, sq_root});
  assign dv_diff = dv_sh - {1'b0, sq_root};
  assign dv_res  = dv_neg ? $signed(16'd0 - {1'b0, dv_q}) : $signed({1'b0, dv_q});

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      stk <= item.stick;
    end
    if (cmd.clamp) begin
      x <= x_cl;
    end else if (cmd.store_x) begin
      x <= dv_res;
    end
    if (cmd.clamp) begin
      y <= y_cl;
    end else if (cmd.store_y) begin
      y <= dv_res;
    end
    if (cmd.sq_x) begin
      sq_xq <= prod[28:0];
    end
    if (cmd.sq_y) begin
      sq_yq <= prod[28:0];
    end
    if (cmd.sum) begin
      r2 <= {1'b0, sq_xq} + {1'b0, sq_yq};
    end
    if (cmd.sqrt_init) begin
      sq_rem  <= '0;
      sq_root <= '0;
      sq_rad  <= r2;
    end else if (cmd.sqrt_step) begin
      sq_rad <= {sq_rad[27:0], 2'b00};
      if (sq_ge) begin
        sq_rem  <= sq_diff[16:0];
        sq_root <= {sq_root[13:0], 1'b1};
      end else begin
        sq_rem  <= sq_sh[16:0];
        sq_root <= {sq_root[13:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      // upper dividend bits are |axis| >> 1, always below the root
      dv_rem <= {1'b0, dv_abs[14:1]};
      dv_num <= {dv_abs[0], 14'd0};
      dv_q   <= '0;
      dv_neg <= dv_src[15];
    end else if (cmd.div_step) begin
      dv_rem <= dv_ge ? dv_diff[14:0] : dv_sh[14:0];
      dv_num <= {dv_num[13:0], 1'b0};
      dv_q   <= {dv_q[13:0], dv_ge};
    end
    if (cmd.out_load) begin
      result.stick_out <= stk;
      result.x_out     <= x;
      result.y_out     <= y;
    end
  end

endmodule
`default_nettype wire

[src/joystick_axis_circle_clamp_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_axis_circle_clamp_core
// Two-stick joystick conditioner with radial clamp to the unit circle.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall/item): each word updates one axis of
// one stick with a raw Q2.14 value. Output channel (result_valid/
// result_stall/result): one word per input, the clamped position of that
// stick, x in [-1,1], y inverted and in [-1,1], pulled onto the unit circle
// when outside it.
// A word inside the circle goes from accept through clamp, both squares,
// the sum and the test to the result; one that must be scaled also takes
// 15 square root steps and two 15-step divides on one shared divider, plus
// setup. One word is worked on at a time; the next input is taken on the
// cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls, a
// finished word waits there and the block holds its next result until the
// register frees. Reset clears the stored axes of both sticks to zero and
// empties the output register.
// ----------------------------------------------------------------------------
module joystick_axis_circle_clamp_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  jsc_pkg::item_t     item,
  output logic               result_valid,
  input  wire logic          result_stall,
  output jsc_pkg::result_t   result
);
  import jsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  jsc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  jsc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

`ifndef ASSERT_OFF
  // a reported position never leaves [-1,1] on either axis
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed(result.x_out) <= ONE_Q14 &&
                      $signed(result.x_out) >= NEG_ONE_Q14 &&
                      $signed(result.y_out) <= ONE_Q14 &&
                      $signed(result.y_out) >= NEG_ONE_Q14))
    else $error("result outside unit range");

  // an accepted word blocks the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("input taken while busy");

  // a stalled result word holds still
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");
`endif

endmodule
`default_nettype wire
